// ===== design/lmghc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lightmap gain and hue clamp: shared package
// Field widths, fixed constants and the record that travels down the
// divider pipeline.
// ----------------------------------------------------------------------------
package lmghc_pkg;

    // Widths of the pixel channels, the gain and the intermediate values
    localparam int CHAN_W  = 8;
    localparam int GAIN_W  = 12;
    localparam int PROD_W  = CHAN_W + GAIN_W;
    localparam int NUM_W   = PROD_W + CHAN_W;
    localparam int CHAN_N  = 3;
    localparam int QUOT_W  = CHAN_W;

    // Largest product that still fits without scaling down (255.0 in Q8)
    localparam logic [PROD_W-1:0] FULL_SCALE_Q8 = PROD_W'(255 * 256);

    // Gain after reset: 2.5 in Q8
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(640);

    // Configuration register indexes
    localparam logic REG_GAIN = 1'b0;

    // Payload of one item inside the divider pipeline
    typedef struct packed {
        logic                           scale;
        logic [PROD_W-1:0]              peak;
        logic [CHAN_N-1:0][NUM_W-1:0]   rem;
        logic [CHAN_N-1:0][QUOT_W-1:0]  quot;
        logic [CHAN_N-1:0][CHAN_W-1:0]  low;
    } div_stage_t;

endpackage

// ===== design/lmghc_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lightmap gain and hue clamp: one divider step
// Produces one quotient bit for each of the three channels by a restoring
// compare and subtract against the peak product shifted to this bit.
// ----------------------------------------------------------------------------
module lmghc_div_stage #(
    parameter int BIT_POS = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  lmghc_pkg::div_stage_t  in_data,
    output logic                   out_valid,
    output lmghc_pkg::div_stage_t  out_data
);

    logic                   valid_reg;
    lmghc_pkg::div_stage_t  data_reg;
    lmghc_pkg::div_stage_t  data_next;
    logic [lmghc_pkg::NUM_W-1:0] divisor;

    // The divisor aligned to the quotient bit of this step
    assign divisor = lmghc_pkg::NUM_W'(in_data.peak) << BIT_POS;

    // Compare and subtract for every channel
    always_comb
    begin
        data_next = in_data;
        for (int c = 0; c < lmghc_pkg::CHAN_N; c++)
        begin
            if (in_data.rem[c] >= divisor)
            begin
                data_next.rem[c]           = in_data.rem[c] - divisor;
                data_next.quot[c][BIT_POS] = 1'b1;
            end
        end
    end

    // Valid bit of the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload of the stage
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef ASSERT_OFF
    // A scaled item keeps each remainder below the divisor of this step.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && data_reg.scale) |->
            (data_reg.rem[0] < (lmghc_pkg::NUM_W'(data_reg.peak) << BIT_POS)) &&
            (data_reg.rem[1] < (lmghc_pkg::NUM_W'(data_reg.peak) << BIT_POS)) &&
            (data_reg.rem[2] < (lmghc_pkg::NUM_W'(data_reg.peak) << BIT_POS)))
        else $error("divider remainder not below the shifted peak");

    // A remainder never grows from one step to the next.
    a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && valid_reg) |=>
            (data_reg.rem[0] <= $past(in_data.rem[0])) &&
            (data_reg.rem[1] <= $past(in_data.rem[1])) &&
            (data_reg.rem[2] <= $past(in_data.rem[2])))
        else $error("divider remainder grew");

    // Scaling down only ever happens against a non-zero peak.
    a_peak_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && data_reg.scale) |-> (data_reg.peak != '0))
        else $error("scaled item with a zero peak");
`endif

endmodule

// ===== design/lightmap_gamma_hue_clamp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lightmap gain and hue clamp
// Brightens an RGB pixel by a Q8 gain and, where the brightest channel would
// pass full scale, scales all three channels down together to keep the hue.
// ----------------------------------------------------------------------------
// Use of the block:
//   An item (red_in, green_in, blue_in) is taken at a rising edge with start
//   high; busy is always low, so one item may be taken every cycle.
//   The result appears on red_out, green_out and blue_out with done high for
//   exactly one cycle; it is taken at the edge that ends that cycle.
//   Pipeline: one multiply stage, one peak stage, eight divider steps and an
//   output register. Throughput: one item per cycle; the eight-step
//   restoring divider is fully pipelined, one quotient bit per stage.
//   The gain register sits at byte address 0 of the APB port, is written in
//   the access phase and reads back in bits 11:0.
//   Reset clears every valid bit and loads the gain with 2.5 (640 in Q8);
//   items in flight are dropped. The receiver cannot hold results off, so
//   nothing in the pipeline ever stalls.
// ----------------------------------------------------------------------------
module lightmap_gamma_hue_clamp (
    input  logic        clk,
    input  logic        rst_n,
    // Item channel
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        done,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LATENCY = 11;

    logic [lmghc_pkg::GAIN_W-1:0]                       gain_reg;
    logic [lmghc_pkg::CHAN_N-1:0][lmghc_pkg::CHAN_W-1:0] chan_in;

    logic                                               s1_valid_reg;
    logic [lmghc_pkg::CHAN_N-1:0][lmghc_pkg::PROD_W-1:0] s1_prod_reg;
    logic [lmghc_pkg::CHAN_N-1:0][lmghc_pkg::PROD_W-1:0] s1_prod_next;

    logic                                               s2_valid_reg;
    lmghc_pkg::div_stage_t                              s2_data_reg;
    lmghc_pkg::div_stage_t                              s2_data_next;
    logic [lmghc_pkg::PROD_W-1:0]                       peak01;

    logic                  div_valid [0:lmghc_pkg::QUOT_W];
    lmghc_pkg::div_stage_t div_data  [0:lmghc_pkg::QUOT_W];

    logic                                               out_valid_reg;
    logic                                               out_scale_reg;
    logic [lmghc_pkg::CHAN_N-1:0][lmghc_pkg::CHAN_W-1:0] out_chan_reg;
    logic [lmghc_pkg::CHAN_N-1:0][lmghc_pkg::CHAN_W-1:0] out_chan_next;

    // Handshake: the pipeline never stalls
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Gain register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= lmghc_pkg::GAIN_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == lmghc_pkg::REG_GAIN))
        begin
            gain_reg <= pwdata[lmghc_pkg::GAIN_W-1:0];
        end
    end

    // Register read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == lmghc_pkg::REG_GAIN)
        begin
            prdata = 32'(gain_reg);
        end
    end

    // Stage 1: channel times gain
    assign chan_in = {blue_in, green_in, red_in};

    always_comb
    begin
        for (int c = 0; c < lmghc_pkg::CHAN_N; c++)
        begin
            s1_prod_next[c] = lmghc_pkg::PROD_W'(chan_in[c]) *
                              lmghc_pkg::PROD_W'(gain_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= s1_prod_next;
    end

    // Stage 2: peak product, scale decision and dividends (p * 255)
    assign peak01 = (s1_prod_reg[1] > s1_prod_reg[0]) ? s1_prod_reg[1] : s1_prod_reg[0];

    always_comb
    begin
        s2_data_next.peak  = (s1_prod_reg[2] > peak01) ? s1_prod_reg[2] : peak01;
        s2_data_next.scale = 1'b0;
        s2_data_next.quot  = '0;
        for (int c = 0; c < lmghc_pkg::CHAN_N; c++)
        begin
            if (s1_prod_reg[c] > lmghc_pkg::FULL_SCALE_Q8)
            begin
                s2_data_next.scale = 1'b1;
            end
            s2_data_next.rem[c] = (lmghc_pkg::NUM_W'(s1_prod_reg[c]) << lmghc_pkg::CHAN_W) -
                                  lmghc_pkg::NUM_W'(s1_prod_reg[c]);
            s2_data_next.low[c] = s1_prod_reg[c][2*lmghc_pkg::CHAN_W-1:lmghc_pkg::CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_data_reg <= s2_data_next;
    end

    // Stages 3 to 10: restoring divider, most significant quotient bit first
    assign div_valid[0] = s2_valid_reg;
    assign div_data[0]  = s2_data_reg;

    for (genvar g = 0; g < lmghc_pkg::QUOT_W; g++)
    begin : g_div
        lmghc_div_stage #(
            .BIT_POS (lmghc_pkg::QUOT_W - 1 - g)
        ) u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    // Stage 11: pick the scaled quotient or the plain shifted product
    always_comb
    begin
        for (int c = 0; c < lmghc_pkg::CHAN_N; c++)
        begin
            out_chan_next[c] = div_data[lmghc_pkg::QUOT_W].scale ?
                               div_data[lmghc_pkg::QUOT_W].quot[c] :
                               div_data[lmghc_pkg::QUOT_W].low[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= div_valid[lmghc_pkg::QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        out_chan_reg  <= out_chan_next;
        out_scale_reg <= div_data[lmghc_pkg::QUOT_W].scale;
    end

    assign done      = out_valid_reg;
    assign red_out   = out_chan_reg[0];
    assign green_out = out_chan_reg[1];
    assign blue_out  = out_chan_reg[2];

`ifndef ASSERT_OFF
    // Every result traces back to an item taken a fixed number of edges before.
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching item");

    // A scaled pixel lands its brightest channel exactly on full scale.
    a_scaled_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_scale_reg) |->
            ((red_out == 8'd255) || (green_out == 8'd255) || (blue_out == 8'd255)))
        else $error("scaled pixel without a full-scale channel");

    // The gain leaves reset at its default value.
    a_gain_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> (gain_reg == lmghc_pkg::GAIN_RESET))
        else $error("gain not at its reset value");
`endif

endmodule

// ===== verif/lmghc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lightmap gain and hue clamp: result checker
// Watches the item and configuration channels of the block, keeps its own
// copy of the gain, works out the brightened pixel for every accepted item
// and compares each result with the oldest pixel still outstanding.
// ----------------------------------------------------------------------------
module lmghc_checker (
    input  logic        clk,
    input  logic        rst_n,
    // Item channel
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic        done,
    input  logic [7:0]  red_out,
    input  logic [7:0]  green_out,
    input  logic [7:0]  blue_out,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    // Status towards the testbench top
    output int          fail_count,
    output int          pending_pixels
);

    typedef struct packed {
        logic [lmghc_pkg::CHAN_W-1:0] red;
        logic [lmghc_pkg::CHAN_W-1:0] green;
        logic [lmghc_pkg::CHAN_W-1:0] blue;
    } rgb_t;

    rgb_t                         expected_pixels[$];
    logic [lmghc_pkg::GAIN_W-1:0] gain_copy;

    initial
    begin
        fail_count     = 0;
        pending_pixels = 0;
        gain_copy      = lmghc_pkg::GAIN_RESET;
    end

    // Brightens one pixel by the gain and, where the brightest channel would
    // pass full scale, scales all three down by the same factor.
    function automatic rgb_t brighten(input rgb_t px,
                                      input logic [lmghc_pkg::GAIN_W-1:0] gain);
        logic [lmghc_pkg::PROD_W-1:0] prod [lmghc_pkg::CHAN_N];
        logic [lmghc_pkg::CHAN_W-1:0] chan [lmghc_pkg::CHAN_N];
        logic [lmghc_pkg::PROD_W-1:0] peak;
        logic [lmghc_pkg::NUM_W-1:0]  scaled;
        rgb_t                         res;
        prod[0] = lmghc_pkg::PROD_W'(px.red)   * lmghc_pkg::PROD_W'(gain);
        prod[1] = lmghc_pkg::PROD_W'(px.green) * lmghc_pkg::PROD_W'(gain);
        prod[2] = lmghc_pkg::PROD_W'(px.blue)  * lmghc_pkg::PROD_W'(gain);
        peak = prod[0];
        if (prod[1] > peak)
            peak = prod[1];
        if (prod[2] > peak)
            peak = prod[2];
        for (int i = 0; i < lmghc_pkg::CHAN_N; i++)
        begin
            if (peak > lmghc_pkg::FULL_SCALE_Q8)
            begin
                scaled  = (lmghc_pkg::NUM_W'(prod[i]) * lmghc_pkg::NUM_W'(255)) /
                          lmghc_pkg::NUM_W'(peak);
                chan[i] = scaled[lmghc_pkg::CHAN_W-1:0];
            end
            else
            begin
                chan[i] = prod[i][lmghc_pkg::CHAN_W+7:8];
            end
        end
        res.red   = chan[0];
        res.green = chan[1];
        res.blue  = chan[2];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // All channels are sampled at the rising edge, before the block or the
    // testbench can change them in the same time step.
    always @(posedge clk)
    begin
        rgb_t got;
        rgb_t want;
        if (!rst_n)
        begin
            gain_copy = lmghc_pkg::GAIN_RESET;
            expected_pixels.delete();
        end
        else
        begin
            // Results leaving the block
            if (done)
            begin
                got = '{red: red_out, green: green_out, blue: blue_out};
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with no item outstanding",
                                              got.red, got.green, got.blue));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red)
                        report_mismatch($sformatf("red_out %0d, expected %0d",
                                                  got.red, want.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("green_out %0d, expected %0d",
                                                  got.green, want.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("blue_out %0d, expected %0d",
                                                  got.blue, want.blue));
                end
            end

            // Items entering the block
            if (start && !busy)
                expected_pixels.insert(expected_pixels.size(),
                                       brighten('{red: red_in, green: green_in,
                                                  blue: blue_in}, gain_copy));

            // Register access completing at this edge
            if (psel && penable && pready && paddr[2] == lmghc_pkg::REG_GAIN)
            begin
                if (pwrite)
                    gain_copy = pwdata[lmghc_pkg::GAIN_W-1:0];
                else if (prdata[lmghc_pkg::GAIN_W-1:0] !== gain_copy)
                    report_mismatch($sformatf("gain reads back %0d, expected %0d",
                                              prdata[lmghc_pkg::GAIN_W-1:0], gain_copy));
            end
        end
        pending_pixels = expected_pixels.size();
    end

endmodule

// ===== verif/tb_lightmap_gamma_hue_clamp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lightmap gain and hue clamp: testbench top
// Drives directed and random pixels through the block under a series of
// gains written over the APB port, with random gaps between items, and
// gives the verdict from the failure and pending-pixel counts of the checker.
// ----------------------------------------------------------------------------
module tb_lightmap_gamma_hue_clamp;

    localparam int CLK_HIGH      = 6;
    localparam int CLK_LOW       = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int DRAIN_CYCLES  = 16;
    localparam int IDLE_GUARD    = 2000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS  = 175;

    // Byte addresses: the gain register, and one index past the register list
    localparam logic [2:0] ADDR_GAIN  = {lmghc_pkg::REG_GAIN, 2'b00};
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    logic [7:0]  red_in    = '0;
    logic [7:0]  green_in  = '0;
    logic [7:0]  blue_in   = '0;
    logic        done;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        busy_seen   = 1'b0;
    logic        pready_seen = 1'b0;
    int          fail_count;
    int          pending_pixels;
    int          cycle_count = 0;

    always
    begin
        #CLK_LOW  clk = 1'b1;
        #CLK_HIGH clk = 1'b0;
    end

    lightmap_gamma_hue_clamp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    lmghc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .red_in         (red_in),
        .green_in       (green_in),
        .blue_in        (blue_in),
        .done           (done),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending_pixels (pending_pixels)
    );

    // The handshake outputs only change at rising edges, so their value at the
    // falling edge is the one that the next rising edge will see.
    always @(negedge clk)
    begin
        busy_seen   <= busy;
        pready_seen <= pready;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles without finishing", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one item and returns at the edge that takes it.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        start    <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        do
            @(posedge clk);
        while (busy_seen);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Mostly back to back, often a short gap, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Channel values lean towards black, full scale and both ends of the range.
    function automatic logic [7:0] pick_channel();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 15));
            3:       return 8'($urandom_range(240, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One APB transfer, after which the bus returns to idle.
    task automatic apb_transfer(input logic write, input logic [2:0] addr,
                                input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready_seen);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every outstanding pixel has come out, then lets the
    // pipeline run empty before the gain may change.
    task automatic wait_idle();
        int guard;
        guard = 0;
        start <= 1'b0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while (pending_pixels != 0 && guard < IDLE_GUARD);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_gain(input logic [lmghc_pkg::GAIN_W-1:0] gain);
        wait_idle();
        apb_transfer(1'b1, ADDR_GAIN, {20'($urandom_range(0, 1048575)), gain});
        apb_transfer(1'b0, ADDR_GAIN, '0);
    endtask

    initial
    begin
        logic [lmghc_pkg::GAIN_W-1:0] gain;
        int                           gap;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset gain of 2.5: black, white, pure channels, a pixel that stays
        // below full scale, one that lands exactly on it and one scaled down.
        apb_transfer(1'b0, ADDR_GAIN, '0);
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd0);
        idle_gap(2);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd100, 8'd50,  8'd25);
        idle_gap(1);
        send_pixel(8'd102, 8'd51,  8'd0);
        send_pixel(8'd103, 8'd20,  8'd1);

        // Zero gain gives black whatever the pixel.
        set_gain(lmghc_pkg::GAIN_W'(0));
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1,   8'd128, 8'd200);

        // Unity gain: full scale passes unchanged.
        set_gain(lmghc_pkg::GAIN_W'(256));
        send_pixel(8'd255, 8'd128, 8'd1);
        send_pixel(8'd254, 8'd0,   8'd127);

        // Largest gain.
        set_gain(lmghc_pkg::GAIN_W'(4095));
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd16,  8'd17,  8'd15);

        // A write past the register list must leave the gain alone.
        wait_idle();
        apb_transfer(1'b1, ADDR_SPARE, 32'h0000_0123);
        apb_transfer(1'b0, ADDR_GAIN, '0);
        send_pixel(8'd128, 8'd64,  8'd32);

        // Upper data bits are dropped; 1020 puts channel 64 exactly on full scale.
        wait_idle();
        apb_transfer(1'b1, ADDR_GAIN, 32'hABCD_E3FC);
        apb_transfer(1'b0, ADDR_GAIN, '0);
        send_pixel(8'd64,  8'd63,  8'd0);
        send_pixel(8'd65,  8'd64,  8'd1);

        // Random phases, each under its own gain.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       gain = lmghc_pkg::GAIN_RESET;
                1:       gain = lmghc_pkg::GAIN_W'(0);
                2:       gain = lmghc_pkg::GAIN_W'(4095);
                3:       gain = lmghc_pkg::GAIN_W'(256);
                4:       gain = lmghc_pkg::GAIN_W'($urandom_range(1, 255));
                5:       gain = lmghc_pkg::GAIN_W'($urandom_range(257, 1023));
                default: gain = lmghc_pkg::GAIN_W'($urandom_range(1024, 4095));
            endcase
            set_gain(gain);
            if (phase == 3)
                apb_transfer(1'b1, ADDR_SPARE, $urandom());
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                send_pixel(pick_channel(), pick_channel(), pick_channel());
                // A stretch of each phase runs with no gaps at all.
                gap = (n >= 50 && n < 90) ? 0 : pick_gap();
                idle_gap(gap);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending_pixels == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            if (pending_pixels != 0)
                $display("%0d expected pixels never came out", pending_pixels);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== lightmap_gamma_hue_clamp.f =====
design/lmghc_pkg.sv
design/lmghc_div_stage.sv
design/lightmap_gamma_hue_clamp.sv
verif/lmghc_checker.sv
verif/tb_lightmap_gamma_hue_clamp.sv
